/* src/fsg_pkg.sv */
// Package for the falling-sand grid block: grid geometry, field widths,
// request codes, neighbor probe codes, sequencer states and cell class helpers.
// Depends on nothing; used by falling_sand_grid_step.
package fsg_pkg;

    // Grid geometry and derived widths.
    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 128;
    localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);
    localparam int COL_W       = $clog2(GRID_WIDTH);
    localparam int ROW_W       = $clog2(GRID_HEIGHT);

    // Field widths of the request and result ports.
    localparam int REQ_W   = 2;
    localparam int COORD_W = 7;
    localparam int CELL_W  = 8;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PASS  = 2'd2;

    // Cell bytes. A byte above 200 is its own class, so only bytes below 20
    // can be sand (0..9) or water (10..19), and air is exactly 255.
    localparam logic [CELL_W-1:0] CELL_AIR    = 8'd255;
    localparam logic [CELL_W-1:0] SAND_LIMIT  = 8'd10;
    localparam logic [CELL_W-1:0] WATER_LIMIT = 8'd20;

    // Neighbor probes of the cell being updated.
    localparam int PRB_W  = 3;
    localparam int NPROBE = 6;
    localparam logic [PRB_W-1:0] PR_ME = 3'd0;  // the cell itself
    localparam logic [PRB_W-1:0] PR_DN = 3'd1;  // straight below
    localparam logic [PRB_W-1:0] PR_DL = 3'd2;  // lower left
    localparam logic [PRB_W-1:0] PR_DR = 3'd3;  // lower right
    localparam logic [PRB_W-1:0] PR_SL = 3'd4;  // left, same row
    localparam logic [PRB_W-1:0] PR_SR = 3'd5;  // right, same row

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_DATA,
        ST_DONE,
        ST_PR_ADDR,
        ST_PR_DATA,
        ST_DECIDE,
        ST_WR_NB,
        ST_WR_ME
    } t_state;

    function automatic logic is_sand(input logic [CELL_W-1:0] v);
        return v < SAND_LIMIT;
    endfunction

    function automatic logic is_water(input logic [CELL_W-1:0] v);
        return (v >= SAND_LIMIT) && (v < WATER_LIMIT);
    endfunction

endpackage

/* src/falling_sand_grid_step.sv */
// Falling-sand grid: write, read, or run one in-place physics pass per request.
// A write or unknown request goes through ST_DONE to the result; a read also passes ST_RD_DATA.
// A pass visits every cell once; a sand or water cell probes its neighbors one at a time
// through the single grid RAM port and the probe sequencer, and may then swap with one.
// One request at a time; the next is taken once the result is in the output register.
// Reset: a clearing pass writes air to all GRID_DEPTH cells (one per cycle) first.
module falling_sand_grid_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [fsg_pkg::REQ_W-1:0]   i_req_type,
    input  logic [fsg_pkg::COORD_W-1:0] i_x_coord,
    input  logic [fsg_pkg::COORD_W-1:0] i_y_coord,
    input  logic [fsg_pkg::CELL_W-1:0]  i_write_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fsg_pkg::CELL_W-1:0]  o_read_value,
    output logic [fsg_pkg::REQ_W-1:0]   o_done_kind
);
    import fsg_pkg::*;

    // Control registers.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_out_valid, n_out_valid;

    // Payload registers.
    logic [COL_W-1:0]               r_col, n_col;
    logic [ROW_W-1:0]               r_y, n_y;
    logic [ADDR_W-1:0]              r_row_base, n_row_base;
    logic [PRB_W-1:0]               r_k, n_k;
    logic [PRB_W-1:0]               r_tgt, n_tgt;
    logic [NPROBE-1:0][CELL_W-1:0]  r_val, n_val;
    logic [NPROBE-1:0]              r_in, n_in;
    logic                           r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0]              r_res_val, n_res_val;
    logic [REQ_W-1:0]               r_res_kind, n_res_kind;
    logic [CELL_W-1:0]              r_read_value;
    logic [REQ_W-1:0]               r_done_kind;

    // RAM port signals.
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    // Request address and range check.
    logic               req_in;
    logic [ADDR_W-1:0]  req_addr;

    // Probe address unit.
    logic [PRB_W-1:0]   addr_sel;
    logic [ADDR_W-1:0]  me_addr, dn_addr, probe_addr;
    logic               probe_in;

    // Scan position and decision.
    logic               row_end, pass_end, probe_last, me_sand;
    logic               step_probe, step_cell, out_load;
    logic               tgt_found;
    logic [PRB_W-1:0]   tgt;
    logic [NPROBE-1:0]  air_f, free_f;

    fsg_ram #(
        .WIDTH (CELL_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Address of a read or write request, and whether it lies in the grid.
    assign req_in   = (32'(i_x_coord) < GRID_WIDTH) && (32'(i_y_coord) < GRID_HEIGHT);
    assign req_addr = ADDR_W'(32'(i_y_coord) * GRID_WIDTH + 32'(i_x_coord));

    // Shared address unit: address and in-grid flag of the selected neighbor.
    assign addr_sel = (r_state == ST_WR_NB) ? r_tgt : r_k;
    assign me_addr  = r_row_base + ADDR_W'(r_col);
    assign dn_addr  = me_addr - ADDR_W'(GRID_WIDTH);

    always_comb begin
        case (addr_sel)
            PR_ME: begin
                probe_addr = me_addr;
                probe_in   = 1'b1;
            end
            PR_DN: begin
                probe_addr = dn_addr;
                probe_in   = (r_y != '0);
            end
            PR_DL: begin
                probe_addr = dn_addr - ADDR_W'(1);
                probe_in   = (r_y != '0) && (r_col != '0);
            end
            PR_DR: begin
                probe_addr = dn_addr + ADDR_W'(1);
                probe_in   = (r_y != '0) && (r_col != COL_W'(GRID_WIDTH - 1));
            end
            PR_SL: begin
                probe_addr = me_addr - ADDR_W'(1);
                probe_in   = (r_col != '0);
            end
            PR_SR: begin
                probe_addr = me_addr + ADDR_W'(1);
                probe_in   = (r_col != COL_W'(GRID_WIDTH - 1));
            end
            default: begin
                probe_addr = me_addr;
                probe_in   = 1'b0;
            end
        endcase
    end

    // Serpentine scan: even rows run left to right, odd rows right to left.
    assign row_end  = r_y[0] ? (r_col == '0) : (r_col == COL_W'(GRID_WIDTH - 1));
    assign pass_end = row_end && (r_y == ROW_W'(GRID_HEIGHT - 1));

    // Sand needs the three cells below; water also needs both side cells.
    assign me_sand    = is_sand(r_val[PR_ME]);
    assign probe_last = (r_k == PR_SR) || (me_sand && (r_k == PR_DR));

    // Per-neighbor class flags; cells outside the grid are neither air nor water.
    always_comb begin
        for (int i = 0; i < NPROBE; i++) begin
            air_f[i]  = r_in[i] && (r_val[i] == CELL_AIR);
            free_f[i] = r_in[i] && ((r_val[i] == CELL_AIR) || is_water(r_val[i]));
        end
    end

    // Move choice for the current cell.
    always_comb begin
        tgt_found = 1'b1;
        tgt       = PR_DN;
        if (me_sand) begin
            if (air_f[PR_DN]) begin
                tgt = PR_DN;
            end else if (free_f[PR_DL]
                         && (!free_f[PR_DR] || (r_val[PR_ME][0] ^ r_col[0]))) begin
                tgt = PR_DL;
            end else if (free_f[PR_DR]) begin
                tgt = PR_DR;
            end else begin
                tgt_found = 1'b0;
            end
        end else begin
            if (air_f[PR_DN]) begin
                tgt = PR_DN;
            end else if (air_f[PR_DL] && (!air_f[PR_DR] || r_val[PR_ME][0])) begin
                tgt = PR_DL;
            end else if (air_f[PR_DR]) begin
                tgt = PR_DR;
            end else if (air_f[PR_SL] && (!air_f[PR_SR] || r_val[PR_ME][0])) begin
                tgt = PR_SL;
            end else if (air_f[PR_SR]) begin
                tgt = PR_SR;
            end else begin
                tgt_found = 1'b0;
            end
        end
    end

    // Sequencer: next state, RAM controls and next payload values.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_col      = r_col;
        n_y        = r_y;
        n_row_base = r_row_base;
        n_k        = r_k;
        n_tgt      = r_tgt;
        n_val      = r_val;
        n_in       = r_in;
        n_rd_ok    = r_rd_ok;
        n_res_val  = r_res_val;
        n_res_kind = r_res_kind;
        ram_we     = 1'b0;
        ram_waddr  = probe_addr;
        ram_wdata  = r_val[PR_ME];
        ram_re     = 1'b0;
        ram_raddr  = probe_addr;
        step_probe = 1'b0;
        step_cell  = 1'b0;
        out_load   = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = CELL_AIR;
                if (r_clr_addr == ADDR_W'(GRID_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_res_kind = i_req_type;
                    n_res_val  = '0;
                    case (i_req_type)
                        REQ_WRITE: begin
                            ram_we    = req_in;
                            ram_waddr = req_addr;
                            ram_wdata = i_write_value;
                            n_state   = ST_DONE;
                        end
                        REQ_READ: begin
                            ram_re    = req_in;
                            ram_raddr = req_addr;
                            n_rd_ok   = req_in;
                            n_state   = ST_RD_DATA;
                        end
                        REQ_PASS: begin
                            n_col      = '0;
                            n_y        = '0;
                            n_row_base = '0;
                            n_k        = PR_ME;
                            n_state    = ST_PR_ADDR;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_DATA: begin
                n_res_val = r_rd_ok ? ram_rdata : '0;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_PR_ADDR: begin
                if (probe_in) begin
                    ram_re  = 1'b1;
                    n_state = ST_PR_DATA;
                end else begin
                    n_in[r_k]  = 1'b0;
                    step_probe = 1'b1;
                end
            end
            ST_PR_DATA: begin
                n_val[r_k] = ram_rdata;
                n_in[r_k]  = 1'b1;
                if (r_k == PR_ME) begin
                    if (is_sand(ram_rdata) || is_water(ram_rdata)) begin
                        n_k     = PR_DN;
                        n_state = ST_PR_ADDR;
                    end else begin
                        step_cell = 1'b1;
                    end
                end else begin
                    step_probe = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (tgt_found) begin
                    n_tgt   = tgt;
                    n_state = ST_WR_NB;
                end else begin
                    step_cell = 1'b1;
                end
            end
            ST_WR_NB: begin
                // The moving cell lands on the chosen neighbor.
                ram_we    = 1'b1;
                ram_waddr = probe_addr;
                ram_wdata = r_val[PR_ME];
                n_state   = ST_WR_ME;
            end
            ST_WR_ME: begin
                // The neighbor's old byte takes the vacated place.
                ram_we    = 1'b1;
                ram_waddr = me_addr;
                ram_wdata = r_val[r_tgt];
                step_cell = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Move on to the next neighbor, or decide once all are in.
        if (step_probe) begin
            if (probe_last) begin
                n_state = ST_DECIDE;
            end else begin
                n_k     = r_k + PRB_W'(1);
                n_state = ST_PR_ADDR;
            end
        end

        // Move on to the next cell; at a row end the column stays put.
        if (step_cell) begin
            if (pass_end) begin
                n_state = ST_DONE;
            end else begin
                n_k     = PR_ME;
                n_state = ST_PR_ADDR;
                if (row_end) begin
                    n_y        = r_y + ROW_W'(1);
                    n_row_base = r_row_base + ADDR_W'(GRID_WIDTH);
                end else if (r_y[0]) begin
                    n_col = r_col - COL_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        end

        // Output register: loaded from the finished request, emptied when taken.
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_y        <= n_y;
        r_row_base <= n_row_base;
        r_k        <= n_k;
        r_tgt      <= n_tgt;
        r_val      <= n_val;
        r_in       <= n_in;
        r_rd_ok    <= n_rd_ok;
        r_res_val  <= n_res_val;
        r_res_kind <= n_res_kind;
        if (out_load) begin
            r_read_value <= r_res_val;
            r_done_kind  <= r_res_kind;
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_done_kind  = r_done_kind;

`ifndef SYNTHESIS
    // The grid RAM is never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("grid RAM read and write in the same cycle");

    // The second half of a swap always follows the first.
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR_ME) |-> ($past(r_state) == ST_WR_NB))
        else $error("swap write without its neighbor write");

    // A move only ever targets a neighbor inside the grid.
    a_tgt_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR_NB) |-> r_in[r_tgt])
        else $error("move targets a cell outside the grid");

    // Only read requests return a nonzero byte.
    a_zero_non_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_done_kind != REQ_READ)) |-> (o_read_value == '0))
        else $error("nonzero value on a non-read result");

    // The clearing pass covers the whole grid before requests are taken.
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (($past(r_state) == ST_CLEAR) && (r_state != ST_CLEAR))
        |-> ($past(r_clr_addr) == ADDR_W'(GRID_DEPTH - 1)))
        else $error("clearing pass ended early");
`endif

endmodule

/* src/fsg_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the cell grid of the falling-sand block.
module fsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for falling_sand_grid_step: directed and random requests,
// each result checked against a cell-grid predictor kept inside this file.
// Depends on fsg_pkg and falling_sand_grid_step.
module tb_top;
    import fsg_pkg::*;

    // Request code that the package leaves unnamed: the block echoes it and does nothing.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    // Cell classes as the predictor sees them.
    localparam int CLASS_LITERAL_ABOVE = 200;
    localparam int CLASS_DIVISOR       = 10;
    localparam int KIND_SAND           = 0;
    localparam int KIND_WATER          = 1;
    localparam int KIND_AIR            = 255;
    localparam int KIND_NONE           = -1;

    // Run shape and bounds.
    localparam int DIRECTED_ROWS = 24;
    localparam int RAND_ITEMS    = 76;
    localparam int QUIET_TAIL    = 20;
    localparam int PASS_SPACING  = 33;
    localparam int MAX_PASSES    = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   =
        (MAX_PASSES * GRID_DEPTH * 15 + GRID_DEPTH + (DIRECTED_ROWS + RAND_ITEMS) * 10) * 4;

    typedef struct {
        logic [CELL_W-1:0] rv;
        logic [REQ_W-1:0]  kind;
    } t_done;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CELL_W-1:0]  wv;
        logic               drain;
        logic               fixed;
        logic [CELL_W-1:0]  fixed_rv;
    } t_stim_row;

    // Directed requests. Rows with the fixed bit carry an expectation typed in by hand;
    // the rest are checked against the predictor.
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // Fresh grid is all air, at both corners.
        '{REQ_READ,    7'd0,   7'd0,   8'd0,   1'b0, 1'b1, 8'd255},
        '{REQ_READ,    7'd127, 7'd127, 8'd255, 1'b0, 1'b1, 8'd255},
        // Unknown request answers zero and echoes its code.
        '{REQ_UNKNOWN, 7'd127, 7'd127, 8'd255, 1'b0, 1'b1, 8'd0},
        '{REQ_UNKNOWN, 7'd0,   7'd0,   8'd0,   1'b0, 1'b1, 8'd0},
        // Sand on stone with water lower left and air lower right: parity picks a side.
        '{REQ_WRITE,   7'd5,   7'd1,   8'd3,   1'b0, 1'b1, 8'd0},
        '{REQ_WRITE,   7'd5,   7'd0,   8'd25,  1'b0, 1'b1, 8'd0},
        '{REQ_WRITE,   7'd4,   7'd0,   8'd12,  1'b0, 1'b1, 8'd0},
        // Water on the left edge above air falls straight down.
        '{REQ_WRITE,   7'd0,   7'd1,   8'd15,  1'b0, 1'b1, 8'd0},
        // Sand at the right edge on stone: lower right is off the grid.
        '{REQ_WRITE,   7'd127, 7'd0,   8'd20,  1'b0, 1'b1, 8'd0},
        '{REQ_WRITE,   7'd127, 7'd1,   8'd9,   1'b0, 1'b1, 8'd0},
        '{REQ_WRITE,   7'd126, 7'd0,   8'd255, 1'b0, 1'b1, 8'd0},
        // Water on the floor can only spread sideways.
        '{REQ_WRITE,   7'd64,  7'd0,   8'd19,  1'b0, 1'b1, 8'd0},
        // Sand in free air, and inert bytes just at and above the literal-class limit.
        '{REQ_WRITE,   7'd65,  7'd3,   8'd0,   1'b0, 1'b1, 8'd0},
        '{REQ_WRITE,   7'd10,  7'd0,   8'd200, 1'b0, 1'b1, 8'd0},
        '{REQ_WRITE,   7'd11,  7'd0,   8'd201, 1'b0, 1'b1, 8'd0},
        // Water in the top corner.
        '{REQ_WRITE,   7'd127, 7'd127, 8'd10,  1'b0, 1'b1, 8'd0},
        // First pass waits for every earlier result to come back.
        '{REQ_PASS,    7'd0,   7'd0,   8'd0,   1'b1, 1'b1, 8'd0},
        '{REQ_READ,    7'd6,   7'd0,   8'd0,   1'b0, 1'b0, 8'd0},
        '{REQ_READ,    7'd126, 7'd0,   8'd0,   1'b0, 1'b0, 8'd0},
        '{REQ_READ,    7'd63,  7'd0,   8'd0,   1'b0, 1'b0, 8'd0},
        '{REQ_READ,    7'd65,  7'd2,   8'd0,   1'b0, 1'b0, 8'd0},
        '{REQ_PASS,    7'd127, 7'd127, 8'd255, 1'b0, 1'b1, 8'd0},
        '{REQ_READ,    7'd127, 7'd126, 8'd0,   1'b0, 1'b0, 8'd0},
        '{REQ_READ,    7'd0,   7'd0,   8'd0,   1'b0, 1'b0, 8'd0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [COORD_W-1:0] i_x_coord = '0;
    logic [COORD_W-1:0] i_y_coord = '0;
    logic [CELL_W-1:0]  i_write_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [CELL_W-1:0]  o_read_value;
    logic [REQ_W-1:0]   o_done_kind;

    logic [CELL_W-1:0] sand_grid_model [GRID_DEPTH];
    t_done             awaited_results [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                stall_left = 0;
    bit                quiet = 1'b0;

    falling_sand_grid_step u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_value  (o_read_value),
        .o_done_kind   (o_done_kind)
    );

    always #1 i_clk = ~i_clk;

    // Class of a cell byte: large bytes stand for themselves, the rest group by tens.
    function automatic int grain_kind(input logic [CELL_W-1:0] v);
        if (int'(v) > CLASS_LITERAL_ABOVE) return int'(v);
        return int'(v) / CLASS_DIVISOR;
    endfunction

    // Class of the cell at (x,y); off-grid cells have no class and block movement.
    function automatic int look_at(input int x, input int y, output int idx);
        idx = 0;
        if (x < 0 || x >= GRID_WIDTH || y < 0 || y >= GRID_HEIGHT) return KIND_NONE;
        idx = y * GRID_WIDTH + x;
        return grain_kind(sand_grid_model[idx]);
    endfunction

    task automatic exchange_cells(input int a, input int b);
        logic [CELL_W-1:0] t;
        t = sand_grid_model[a];
        sand_grid_model[a] = sand_grid_model[b];
        sand_grid_model[b] = t;
    endtask

    // Moves one sand or water cell, in place, by at most one swap.
    task automatic settle_cell(input int x, input int y);
        int me, il, iu, ir, isl, isr;
        int kme, kl, ku, kr, ksl, ksr;
        logic [CELL_W-1:0] v;
        bit odd, left_free, right_free;
        kme = look_at(x, y, me);
        if (kme != KIND_SAND && kme != KIND_WATER) return;
        v  = sand_grid_model[me];
        kl = look_at(x - 1, y - 1, il);
        ku = look_at(x, y - 1, iu);
        kr = look_at(x + 1, y - 1, ir);
        if (kme == KIND_SAND) begin
            // Sand sinks through water on the diagonals as well as air.
            odd        = ((int'(v) + x) % 2) != 0;
            left_free  = (kl == KIND_AIR) || (kl == KIND_WATER);
            right_free = (kr == KIND_AIR) || (kr == KIND_WATER);
            if (ku == KIND_AIR) exchange_cells(iu, me);
            else if (left_free && (!right_free || odd)) exchange_cells(il, me);
            else if (right_free) exchange_cells(ir, me);
        end else begin
            odd = v[0];
            ksl = look_at(x - 1, y, isl);
            ksr = look_at(x + 1, y, isr);
            if (ku == KIND_AIR) exchange_cells(iu, me);
            else if (kl == KIND_AIR && (kr != KIND_AIR || odd)) exchange_cells(il, me);
            else if (kr == KIND_AIR) exchange_cells(ir, me);
            else if (ksl == KIND_AIR && (ksr != KIND_AIR || odd)) exchange_cells(isl, me);
            else if (ksr == KIND_AIR) exchange_cells(isr, me);
        end
    endtask

    // One physics pass: rows bottom up, even rows left to right, odd rows right to left.
    task automatic run_pass_model();
        int col;
        for (int y = 0; y < GRID_HEIGHT; y++) begin
            for (int i = 0; i < GRID_WIDTH; i++) begin
                col = (y % 2 != 0) ? (GRID_WIDTH - 1 - i) : i;
                settle_cell(col, y);
            end
        end
    endtask

    // Applies one request to the grid model and returns the result it should produce.
    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y, input logic [CELL_W-1:0] wv,
                                   output t_done want);
        int idx;
        idx       = int'(y) * GRID_WIDTH + int'(x);
        want.rv   = '0;
        want.kind = req;
        case (req)
            REQ_WRITE: sand_grid_model[idx] = wv;
            REQ_READ:  want.rv = sand_grid_model[idx];
            REQ_PASS:  run_pass_model();
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    task automatic check_result();
        t_done want;
        if (awaited_results.size() == 0) begin
            note_mismatch("unexpected result, kind", int'(o_done_kind), -1);
        end else begin
            want = awaited_results.pop_front();
            if (o_read_value !== want.rv) begin
                note_mismatch("read_value", int'(o_read_value), int'(want.rv));
            end
            if (o_done_kind !== want.kind) begin
                note_mismatch("done_kind", int'(o_done_kind), int'(want.kind));
            end
        end
    endtask

    // Offers one request, waits for it to be taken, then records what it should produce.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [CELL_W-1:0] wv,
                                input bit drain, input bit fixed,
                                input logic [CELL_W-1:0] fixed_rv);
        t_done want;
        if (drain) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (awaited_results.size() != 0) @(posedge i_clk);
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_write_value <= wv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(req, x, y, wv, want);
        if (fixed) begin
            want.rv   = fixed_rv;
            want.kind = req;
        end
        awaited_results.push_back(want);
    endtask

    // Result side: check accepted results, then stall in short random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result();
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        logic [REQ_W-1:0]   req;
        logic [COORD_W-1:0] x, y;
        logic [CELL_W-1:0]  wv;
        int pick;
        for (int i = 0; i < GRID_DEPTH; i++) sand_grid_model[i] = CELL_AIR;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(DIRECTED[r].req, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].wv,
                         DIRECTED[r].drain, DIRECTED[r].fixed, DIRECTED[r].fixed_rv);
        end

        // Random requests, aimed mostly at the bottom rows near both side walls so that
        // passes find piles to move and reads land on cells that moved.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= RAND_ITEMS - QUIET_TAIL);
            pick  = $urandom_range(0, 99);
            x     = COORD_W'($urandom_range(0, 127));
            y     = COORD_W'($urandom_range(0, 127));
            wv    = CELL_W'($urandom_range(0, 255));
            if (n % PASS_SPACING == PASS_SPACING - 1) begin
                req = REQ_PASS;
            end else if (pick < 5) begin
                req = REQ_UNKNOWN;
            end else begin
                req = (pick < 55) ? REQ_WRITE : REQ_READ;
                if ($urandom_range(0, 9) < 7) begin
                    x = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 11)
                                                      : $urandom_range(116, 127));
                    y = COORD_W'($urandom_range(0, 5));
                end
                if (req == REQ_WRITE) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) wv = CELL_W'($urandom_range(0, 9));
                    else if (pick < 7) wv = CELL_W'($urandom_range(10, 19));
                    else if (pick == 7) wv = CELL_AIR;
                end
            end
            send_request(req, x, y, wv, 1'b0, 1'b0, '0);
        end

        // Let the last results drain, then allow a few more cycles for strays.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* falling_sand_grid_step.f */
src/fsg_pkg.sv
src/fsg_ram.sv
src/falling_sand_grid_step.sv
tb/tb_top.sv
